// ----- sv/rvq_pkg.sv -----
// ----------------------------------------------------------------------------
// Rotation vector to quaternion - shared definitions
// Stage counts, fixed-point angle constants, series reciprocals and the
// sideband structures passed between the pipeline sections.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rvq_pkg;

	localparam int SQRT_STAGES  = 24;
	localparam int SERIES_STEPS = 9;
	localparam int TRIG_STAGES  = 3 + 2 * SERIES_STEPS + 1;
	localparam int QUO_BITS     = 16;
	localparam int SCALE_STAGES = 1 + QUO_BITS;
	localparam int LATENCY      = 2 + SQRT_STAGES + TRIG_STAGES + SCALE_STAGES + 1;

	// pi, pi/2 and 2*pi in Q30
	localparam logic [32:0] PI_Q30      = 33'd3373259426;
	localparam logic [32:0] HALF_PI_Q30 = 33'd1686629713;
	localparam logic [32:0] TWO_PI_Q30  = 33'd6746518852;
	localparam logic [31:0] ONE_Q30     = 32'd1073741824;
	localparam logic [16:0] Q14_ONE     = 17'd16384;

	// floor(n / d) == (n * ceil(2^41 / d)) >> 41 for any 32-bit n, d < 512
	localparam int          RECIP_SHIFT = 41;
	localparam logic [63:0] RECIP_ONE   = 64'd1 << RECIP_SHIFT;

	localparam logic [40:0] SIN_RECIP [0:8] = '{
		41'((RECIP_ONE + 64'd5) / 64'd6),
		41'((RECIP_ONE + 64'd19) / 64'd20),
		41'((RECIP_ONE + 64'd41) / 64'd42),
		41'((RECIP_ONE + 64'd71) / 64'd72),
		41'((RECIP_ONE + 64'd109) / 64'd110),
		41'((RECIP_ONE + 64'd155) / 64'd156),
		41'((RECIP_ONE + 64'd209) / 64'd210),
		41'((RECIP_ONE + 64'd271) / 64'd272),
		41'((RECIP_ONE + 64'd341) / 64'd342)
	};

	localparam logic [40:0] COS_RECIP [0:8] = '{
		41'((RECIP_ONE + 64'd1) / 64'd2),
		41'((RECIP_ONE + 64'd11) / 64'd12),
		41'((RECIP_ONE + 64'd29) / 64'd30),
		41'((RECIP_ONE + 64'd55) / 64'd56),
		41'((RECIP_ONE + 64'd89) / 64'd90),
		41'((RECIP_ONE + 64'd131) / 64'd132),
		41'((RECIP_ONE + 64'd181) / 64'd182),
		41'((RECIP_ONE + 64'd239) / 64'd240),
		41'((RECIP_ONE + 64'd305) / 64'd306)
	};

	// per-item sideband: component magnitudes, signs, zero vector, length
	typedef struct packed {
		logic [2:0][15:0] mag;
		logic [2:0]       neg;
		logic             zero;
		logic [23:0]      root;
	} side_t;

	typedef struct packed {
		logic [31:0] sn;
		logic [31:0] cs;
		logic        sneg;
		logic        cneg;
		side_t       side;
	} trig_res_t;

	typedef struct packed {
		logic [2:0][15:0] quo;
		logic [2:0]       ovf;
		logic [16:0]      mag_w;
		logic             sneg;
		logic             cneg;
		side_t            side;
	} scale_res_t;

endpackage

// ----- sv/rvq_sqrt.sv -----
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One root bit per stage; gives floor(sqrt(sum * 2^16)) as the Q20 length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rvq_sqrt (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [31:0]    in_sum,
	input  rvq_pkg::side_t in_side,
	output logic           out_valid,
	output rvq_pkg::side_t out_side
);

	localparam int N = rvq_pkg::SQRT_STAGES;

	logic           vld  [1:N];
	logic [25:0]    rem  [1:N];
	logic [23:0]    root [1:N];
	logic [47:0]    rad  [1:N];
	rvq_pkg::side_t side [1:N];

	for (genvar i = 0; i < N; i++) begin : g_step
		logic           v_in;
		logic [25:0]    rem_in;
		logic [23:0]    root_in;
		logic [47:0]    rad_in;
		rvq_pkg::side_t side_in;
		logic [26:0]    cur;
		logic [26:0]    trial;
		logic           fit;

		if (i == 0) begin : g_head
			assign v_in    = in_valid;
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = {in_sum, 16'd0};
			assign side_in = in_side;
		end else begin : g_body
			assign v_in    = vld[i];
			assign rem_in  = rem[i];
			assign root_in = root[i];
			assign rad_in  = rad[i];
			assign side_in = side[i];
		end

		// bring down two radicand bits, try root*4 + 1
		assign cur   = {rem_in[24:0], rad_in[47:46]};
		assign trial = {1'b0, root_in, 2'b01};
		assign fit   = cur >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[i+1] <= 1'b0;
			end else begin
				vld[i+1] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			rem[i+1]  <= fit ? 26'(cur - trial) : cur[25:0];
			root[i+1] <= {root_in[22:0], fit};
			rad[i+1]  <= {rad_in[45:0], 2'b00};
			side[i+1] <= side_in;
		end
	end

	assign out_valid = vld[N];

	always_comb begin
		out_side      = side[N];
		out_side.root = root[N];
	end

endmodule

// ----- sv/rvq_trig.sv -----
// ----------------------------------------------------------------------------
// Half-angle sine and cosine
// Folds the half angle into [-pi/2, pi/2] and runs both Taylor series as a
// chain of multiply / reciprocal-divide stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rvq_trig (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  rvq_pkg::side_t     in_side,
	output logic               out_valid,
	output rvq_pkg::trig_res_t out_res
);

	localparam int K  = rvq_pkg::SERIES_STEPS;
	localparam int RS = rvq_pkg::RECIP_SHIFT;

	localparam logic signed [34:0] PI_A     = 35'(rvq_pkg::PI_Q30);
	localparam logic signed [34:0] HALF_A   = 35'(rvq_pkg::HALF_PI_Q30);
	localparam logic signed [34:0] TWO_PI_A = 35'(rvq_pkg::TWO_PI_Q30);

	// stage 1: half angle, wrap past pi
	logic signed [34:0] hang;
	logic signed [34:0] ang1;
	logic               v_s1;
	logic signed [34:0] ang_s1;
	rvq_pkg::side_t     side_s1;

	assign hang = 35'({in_side.root, 9'd0});
	assign ang1 = (hang > PI_A) ? hang - TWO_PI_A : hang;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		ang_s1  <= ang1;
		side_s1 <= in_side;
	end

	// stage 2: fold into the first half turn
	logic signed [34:0] ang2;
	logic               fold;
	logic               v_s2;
	logic [30:0]        u_s2;
	logic               sneg_s2;
	logic               cneg_s2;
	rvq_pkg::side_t     side_s2;

	always_comb begin
		ang2 = ang_s1;
		fold = 1'b0;
		if (ang_s1 > HALF_A) begin
			ang2 = PI_A - ang_s1;
			fold = 1'b1;
		end else if (ang_s1 < -HALF_A) begin
			ang2 = -PI_A - ang_s1;
			fold = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		u_s2    <= ang2[34] ? 31'(-ang2) : ang2[30:0];
		sneg_s2 <= ang2[34];
		cneg_s2 <= fold;
		side_s2 <= side_s1;
	end

	// stage 3 and series chain
	logic [61:0]        usq;
	logic               vb    [0:K];
	logic [31:0]        tb_s  [0:K];
	logic [31:0]        tb_c  [0:K];
	logic signed [34:0] sb_s  [0:K];
	logic signed [34:0] sb_c  [0:K];
	logic [31:0]        u2b   [0:K-1];
	logic               snb   [0:K];
	logic               cnb   [0:K];
	rvq_pkg::side_t     sideb [0:K];

	logic               va    [0:K-1];
	logic [31:0]        pa_s  [0:K-1];
	logic [31:0]        pa_c  [0:K-1];
	logic signed [34:0] sa_s  [0:K-1];
	logic signed [34:0] sa_c  [0:K-1];
	logic [31:0]        u2a   [0:K-1];
	logic               sna   [0:K-1];
	logic               cna   [0:K-1];
	rvq_pkg::side_t     sidea [0:K-1];

	assign usq = 62'(u_s2) * 62'(u_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vb[0] <= 1'b0;
		end else begin
			vb[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		tb_s[0]  <= 32'(u_s2);
		tb_c[0]  <= rvq_pkg::ONE_Q30;
		sb_s[0]  <= '0;
		sb_c[0]  <= '0;
		u2b[0]   <= usq[61:30];
		snb[0]   <= sneg_s2;
		cnb[0]   <= cneg_s2;
		sideb[0] <= side_s2;
	end

	for (genvar k = 0; k < K; k++) begin : g_term
		logic [63:0]        prod_s;
		logic [63:0]        prod_c;
		logic [72:0]        scl_s;
		logic [72:0]        scl_c;
		logic signed [34:0] add_s;
		logic signed [34:0] add_c;

		assign prod_s = 64'(tb_s[k]) * 64'(u2b[k]);
		assign prod_c = 64'(tb_c[k]) * 64'(u2b[k]);

		// accumulate term k with alternating sign
		if (k % 2 == 0) begin : g_pos
			assign add_s = sb_s[k] + 35'(tb_s[k]);
			assign add_c = sb_c[k] + 35'(tb_c[k]);
		end else begin : g_neg
			assign add_s = sb_s[k] - 35'(tb_s[k]);
			assign add_c = sb_c[k] - 35'(tb_c[k]);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				va[k] <= 1'b0;
			end else begin
				va[k] <= vb[k];
			end
		end

		always_ff @(posedge clk) begin
			pa_s[k]  <= prod_s[61:30];
			pa_c[k]  <= prod_c[61:30];
			sa_s[k]  <= add_s;
			sa_c[k]  <= add_c;
			u2a[k]   <= u2b[k];
			sna[k]   <= snb[k];
			cna[k]   <= cnb[k];
			sidea[k] <= sideb[k];
		end

		// exact divide by the series denominator
		assign scl_s = 73'(pa_s[k]) * 73'(rvq_pkg::SIN_RECIP[k]);
		assign scl_c = 73'(pa_c[k]) * 73'(rvq_pkg::COS_RECIP[k]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vb[k+1] <= 1'b0;
			end else begin
				vb[k+1] <= va[k];
			end
		end

		always_ff @(posedge clk) begin
			tb_s[k+1]  <= scl_s[RS+31:RS];
			tb_c[k+1]  <= scl_c[RS+31:RS];
			sb_s[k+1]  <= sa_s[k];
			sb_c[k+1]  <= sa_c[k];
			snb[k+1]   <= sna[k];
			cnb[k+1]   <= cna[k];
			sideb[k+1] <= sidea[k];
		end

		if (k < K - 1) begin : g_u2
			always_ff @(posedge clk) begin
				u2b[k+1] <= u2a[k];
			end
		end
	end

	// last term carries a minus sign; clamp a negative sum to zero
	logic signed [34:0] fin_s;
	logic signed [34:0] fin_c;

	assign fin_s = sb_s[K] - 35'(tb_s[K]);
	assign fin_c = sb_c[K] - 35'(tb_c[K]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= vb[K];
		end
	end

	always_ff @(posedge clk) begin
		out_res.sn   <= fin_s[34] ? '0 : fin_s[31:0];
		out_res.cs   <= fin_c[34] ? '0 : fin_c[31:0];
		out_res.sneg <= snb[K];
		out_res.cneg <= cnb[K];
		out_res.side <= sideb[K];
	end

endmodule

// ----- sv/rvq_scale.sv -----
// ----------------------------------------------------------------------------
// Vector part scaling
// Forms component * sine + length/2 and divides by the length, one quotient
// bit per stage in three lanes; rounds the cosine to Q14.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rvq_scale (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  rvq_pkg::trig_res_t  in_res,
	output logic                out_valid,
	output rvq_pkg::scale_res_t out_res
);

	localparam int Q = rvq_pkg::QUO_BITS;

	logic           vs   [0:Q];
	logic [48:0]    rem  [0:Q][0:2];
	logic [Q-1:0]   quo  [0:Q][0:2];
	logic           ovf  [1:Q][0:2];
	logic [31:0]    den  [0:Q];
	logic [16:0]    magw [0:Q];
	logic           sg   [0:Q];
	logic           cg   [0:Q];
	rvq_pkg::side_t sd   [0:Q];

	logic [32:0] cs_rnd;

	assign cs_rnd = {1'b0, in_res.cs} + 33'd32768;

	// stage 1: numerators and rounded cosine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vs[0] <= 1'b0;
		end else begin
			vs[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		den[0]  <= {in_res.side.root, 8'd0};
		magw[0] <= cs_rnd[32:16];
		sg[0]   <= in_res.sneg;
		cg[0]   <= in_res.cneg;
		sd[0]   <= in_res.side;
	end

	for (genvar l = 0; l < 3; l++) begin : g_num
		always_ff @(posedge clk) begin
			rem[0][l] <= 49'(in_res.side.mag[l]) * 49'(in_res.sn)
				+ 49'({in_res.side.root, 7'd0});
			quo[0][l] <= '0;
		end
	end

	// restoring divide, MSB first
	for (genvar i = 0; i < Q; i++) begin : g_bit
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vs[i+1] <= 1'b0;
			end else begin
				vs[i+1] <= vs[i];
			end
		end

		always_ff @(posedge clk) begin
			den[i+1]  <= den[i];
			magw[i+1] <= magw[i];
			sg[i+1]   <= sg[i];
			cg[i+1]   <= cg[i];
			sd[i+1]   <= sd[i];
		end

		for (genvar l = 0; l < 3; l++) begin : g_lane
			logic [48:0] trial;
			logic        fit;

			assign trial = 49'(den[i]) << (Q - 1 - i);
			assign fit   = rem[i][l] >= trial;

			always_ff @(posedge clk) begin
				rem[i+1][l] <= fit ? rem[i][l] - trial : rem[i][l];
				quo[i+1][l] <= {quo[i][l][Q-2:0], fit};
			end

			// quotient too large for the register: clamp later
			if (i == 0) begin : g_ovf
				always_ff @(posedge clk) begin
					ovf[1][l] <= rem[0][l] >= (49'(den[0]) << Q);
				end
			end else begin : g_hold
				always_ff @(posedge clk) begin
					ovf[i+1][l] <= ovf[i][l];
				end
			end
		end
	end

	assign out_valid = vs[Q];

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			out_res.quo[l] = quo[Q][l];
			out_res.ovf[l] = ovf[Q][l];
		end
		out_res.mag_w = magw[Q];
		out_res.sneg  = sg[Q];
		out_res.cneg  = cg[Q];
		out_res.side  = sd[Q];
	end

endmodule

// ----- sv/rotation_vector_to_quaternion_unit.sv -----
// ----------------------------------------------------------------------------
// Rotation vector to unit quaternion
// Exponential map of a Q3.12 rotation vector to a Q1.14 quaternion.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Drive a beat with start and the three Q3.12 components; it is taken at
// every clock edge where start is high, and busy never rises, so one vector
// can go in every cycle. Each vector yields exactly one quaternion, shown on
// quat_x/y/z/w for a single cycle with done high; between the beat and the
// result lie 2 input stages, 24 square-root stages, 22 sine/cosine stages,
// 17 scaling/divide stages and 1 output register. Results leave in input order
// and cannot be held off, so capture them whenever done is high. A zero
// vector gives (0, 0, 0, 1.0). All parts saturate to +/-16384 (+/-1.0).
// Half angles beyond pi are not folded to the shorter rotation.

module rotation_vector_to_quaternion_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] comp_x,
	input  logic signed [15:0] comp_y,
	input  logic signed [15:0] comp_z,
	output logic               done,
	output logic signed [15:0] quat_x,
	output logic signed [15:0] quat_y,
	output logic signed [15:0] quat_z,
	output logic signed [15:0] quat_w
);

	// fully pipelined: never hold off a beat
	assign busy = 1'b0;

	// stage 1: split components into magnitude and sign
	logic           v_s1;
	rvq_pkg::side_t side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		side_s1.mag[0] <= comp_x[15] ? 16'(-comp_x) : comp_x;
		side_s1.mag[1] <= comp_y[15] ? 16'(-comp_y) : comp_y;
		side_s1.mag[2] <= comp_z[15] ? 16'(-comp_z) : comp_z;
		side_s1.neg    <= {comp_z[15], comp_y[15], comp_x[15]};
		side_s1.zero   <= (comp_x == 16'sd0) && (comp_y == 16'sd0) && (comp_z == 16'sd0);
		side_s1.root   <= '0;
	end

	// stage 2: squared length in Q24
	logic           v_s2;
	logic [31:0]    sum_s2;
	rvq_pkg::side_t side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		sum_s2  <= 32'(side_s1.mag[0]) * 32'(side_s1.mag[0])
			+ 32'(side_s1.mag[1]) * 32'(side_s1.mag[1])
			+ 32'(side_s1.mag[2]) * 32'(side_s1.mag[2]);
		side_s2 <= side_s1;
	end

	// length, half-angle sine/cosine, scaling
	logic                v_len;
	rvq_pkg::side_t      side_len;
	logic                v_trig;
	rvq_pkg::trig_res_t  trig_res;
	logic                v_scl;
	rvq_pkg::scale_res_t scl_res;

	rvq_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.in_sum    (sum_s2),
		.in_side   (side_s2),
		.out_valid (v_len),
		.out_side  (side_len)
	);

	rvq_trig u_trig (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_len),
		.in_side   (side_len),
		.out_valid (v_trig),
		.out_res   (trig_res)
	);

	rvq_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_trig),
		.in_res    (trig_res),
		.out_valid (v_scl),
		.out_res   (scl_res)
	);

	// clamp to one, then apply the sign (a zero magnitude stays positive)
	function automatic logic [15:0] pack_q14(input logic [16:0] mag, input logic neg);
		logic [16:0] lim;
		lim = (mag > rvq_pkg::Q14_ONE) ? rvq_pkg::Q14_ONE : mag;
		return (neg && lim != '0) ? 16'(-lim) : lim[15:0];
	endfunction

	logic [16:0] lane_mag [0:2];
	logic [15:0] lane_val [0:2];

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			lane_mag[l] = scl_res.ovf[l] ? rvq_pkg::Q14_ONE : {1'b0, scl_res.quo[l]};
			lane_val[l] = pack_q14(lane_mag[l], scl_res.side.neg[l] ^ scl_res.sneg);
		end
	end

	// output register: one beat per result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_scl;
		end
	end

	always_ff @(posedge clk) begin
		if (scl_res.side.zero) begin
			quat_x <= '0;
			quat_y <= '0;
			quat_z <= '0;
			quat_w <= rvq_pkg::Q14_ONE[15:0];
		end else begin
			quat_x <= lane_val[0];
			quat_y <= lane_val[1];
			quat_z <= lane_val[2];
			quat_w <= pack_q14(scl_res.mag_w, scl_res.cneg);
		end
	end

`ifndef SYNTHESIS
	a_latency : assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(rvq_pkg::LATENCY) done)
		else $error("accepted beat did not produce a result on time");

	a_no_stray : assert property (@(posedge clk) disable iff (!arst_n)
		!start |-> ##(rvq_pkg::LATENCY) !done)
		else $error("result without an accepted beat");

	a_zero_vec : assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && comp_x == 16'sd0 && comp_y == 16'sd0 && comp_z == 16'sd0)
		|-> ##(rvq_pkg::LATENCY)
		(done && quat_x == 16'sd0 && quat_y == 16'sd0 && quat_z == 16'sd0
			&& quat_w == 16'sd16384))
		else $error("zero vector did not give the identity quaternion");

	a_clamp : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (quat_x <= 16'sd16384 && quat_x >= -16'sd16384
			&& quat_w <= 16'sd16384 && quat_w >= -16'sd16384))
		else $error("quaternion part out of range");
`endif

endmodule
